// ===== hw/rtl/rti_pkg.sv =====
// Shared constants and types for the ray/triangle intersection tester.
`timescale 1ns / 1ps
package rti_pkg;

   localparam int CoordWidth   = 20;
   localparam int FractionBits = 12;
   localparam int DistWidth    = 24;
   localparam int DiffWidth    = CoordWidth + 1;
   localparam int MinorWidth   = 2 * DiffWidth + 1;
   localparam int ProdWidth    = DiffWidth + MinorWidth;
   localparam int DetWidth     = ProdWidth + 3;
   localparam int DivWidth     = DetWidth + DistWidth;
   localparam int StepWidth    = DistWidth + CoordWidth + 1;
   localparam int VecWidth     = 3 * CoordWidth;
   localparam int CsrIndexWidth = 3;

   localparam logic [CsrIndexWidth-1:0] CSR_VERTEX_A       = 3'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_VERTEX_B       = 3'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_VERTEX_C       = 3'd2;
   localparam logic [CsrIndexWidth-1:0] CSR_SURFACE_NORMAL = 3'd3;
   localparam logic [CsrIndexWidth-1:0] CSR_HIT_EPSILON    = 3'd4;
   localparam logic [CsrIndexWidth-1:0] CSR_SHADOW_ENABLE  = 3'd5;

   // Three packed coordinates, x in the lowest element.
   typedef logic [2:0][CoordWidth-1:0] vec_type;

   // Per-ray data that travels beside the arithmetic.
   typedef struct packed {
      logic    kind;
      logic    quiet;
      vec_type origin;
      vec_type dir;
   } side_type;

   // Finished result before the normal is attached.
   typedef struct packed {
      logic                 hit;
      logic                 primary;
      logic [DistWidth-1:0] distance;
      vec_type              point;
   } result_type;

endpackage

// ===== hw/rtl/ray_triangle_intersect_core.sv =====
// Top level of the pipelined ray/triangle intersection tester.
`timescale 1ns / 1ps
// The core tests one ray per cycle against a triangle held in configuration
// registers, solving for barycentric beta, gamma and distance t by Cramer's rule
// on exact integer determinants. It accepts a new word on every cycle in which
// the pipeline advances. Seven stages form the minors, determinants and hit
// tests, 25 stages divide out t one quotient bit at a time, and two stages
// form the hit point and hold the result. The whole pipeline advances together
// whenever the result register is empty or being taken, so a stall on the
// result side holds every stage and loses nothing. Rays miss when the
// denominator is zero, when beta or gamma is negative, when beta+gamma exceeds
// one or when t is below hit_epsilon; a missed result is all zeros. Shadow
// queries return only the distance and always miss while shadow_enable is
// clear. Configuration should only be written while no ray is in flight.
module ray_triangle_intersect_core (
   input  logic                                clock,
   input  logic                                reset,
   // Ray in.
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [119:0]                        req_tdata,   // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z
   input  logic [0:0]                          req_tuser,   // kind
   // Result out.
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [143:0]                        rsp_tdata,   // distance, point_x..z, normal_x..z
   output logic [0:0]                          rsp_tuser,   // hit
   // Configuration writes.
   input  logic                                csr_we,
   input  logic [rti_pkg::CsrIndexWidth-1:0]   csr_index,
   input  logic [rti_pkg::VecWidth-1:0]        csr_wdata
);

   localparam int VW = rti_pkg::VecWidth;
   localparam int QW = rti_pkg::DistWidth;

   // Configuration registers, reset to a thin triangle in the xz plane whose
   // normal points along y.
   logic [VW-1:0] vertex_a_ff, vertex_b_ff, vertex_c_ff, normal_ff;
   logic [QW-1:0] epsilon_ff;
   logic          shadow_ff;

   logic                advance;
   rti_pkg::side_type   side_in;
   logic                solve_valid, div_valid, pt_valid;
   rti_pkg::side_type   solve_side, div_side;
   logic                solve_miss, div_miss;
   logic [rti_pkg::DivWidth-1:0] solve_num, solve_den;
   logic [QW-1:0]       div_t;
   rti_pkg::result_type pt_result;
   rti_pkg::vec_type    normal_out;

   always_ff @(posedge clock) begin
      if (reset) begin
         vertex_a_ff <= '0;
         vertex_b_ff <= VW'(64'd4096);
         vertex_c_ff <= VW'(64'd4398046511104);
         normal_ff   <= VW'(64'd4294967296);
         epsilon_ff  <= QW'(4);
         shadow_ff   <= 1'b1;
      end else if (csr_we) begin
         unique case (csr_index)
            rti_pkg::CSR_VERTEX_A:       vertex_a_ff <= csr_wdata;
            rti_pkg::CSR_VERTEX_B:       vertex_b_ff <= csr_wdata;
            rti_pkg::CSR_VERTEX_C:       vertex_c_ff <= csr_wdata;
            rti_pkg::CSR_SURFACE_NORMAL: normal_ff   <= csr_wdata;
            rti_pkg::CSR_HIT_EPSILON:    epsilon_ff  <= csr_wdata[QW-1:0];
            rti_pkg::CSR_SHADOW_ENABLE:  shadow_ff   <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Every stage moves when the result register can take a new word.
   assign advance    = ~pt_valid | rsp_tready;
   assign req_tready = advance;

   assign side_in.kind   = req_tuser[0];
   assign side_in.quiet  = req_tuser[0] & ~shadow_ff;
   assign side_in.origin = req_tdata[VW-1:0];
   assign side_in.dir    = req_tdata[2*VW-1:VW];

   rti_solve u_solve (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req_tvalid),
      .in_side   (side_in),
      .vertex_a  (vertex_a_ff),
      .vertex_b  (vertex_b_ff),
      .vertex_c  (vertex_c_ff),
      .out_valid (solve_valid),
      .out_side  (solve_side),
      .out_miss  (solve_miss),
      .out_num   (solve_num),
      .out_den   (solve_den)
   );

   rti_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (solve_valid),
      .in_side   (solve_side),
      .in_miss   (solve_miss),
      .in_num    (solve_num),
      .in_den    (solve_den),
      .out_valid (div_valid),
      .out_side  (div_side),
      .out_miss  (div_miss),
      .out_t     (div_t)
   );

   rti_point u_point (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .in_valid    (div_valid),
      .in_side     (div_side),
      .in_miss     (div_miss),
      .in_t        (div_t),
      .hit_epsilon (epsilon_ff),
      .out_valid   (pt_valid),
      .out_result  (pt_result)
   );

   // The normal is only reported on primary hits. It is attached here; the user must keep
   // configuration stable while results are in flight, as the block does not enforce it.
   assign normal_out = pt_result.primary ? normal_ff : '0;

   assign rsp_tvalid = pt_valid;
   assign rsp_tuser  = pt_result.hit;
   assign rsp_tdata  = {normal_out, pt_result.point, pt_result.distance};

endmodule

// ===== hw/rtl/rti_solve.sv =====
// Cramer's rule front end: determinants, sign normalisation and the hit tests.
`timescale 1ns / 1ps
module rti_solve (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 advance,
   input  logic                                 in_valid,
   input  rti_pkg::side_type                    in_side,
   input  rti_pkg::vec_type                     vertex_a,
   input  rti_pkg::vec_type                     vertex_b,
   input  rti_pkg::vec_type                     vertex_c,
   output logic                                 out_valid,
   output rti_pkg::side_type                    out_side,
   output logic                                 out_miss,
   output logic [rti_pkg::DivWidth-1:0]         out_num,
   output logic [rti_pkg::DivWidth-1:0]         out_den
);

   localparam int DW = rti_pkg::DiffWidth;
   localparam int MW = rti_pkg::MinorWidth;
   localparam int PW = rti_pkg::ProdWidth;
   localparam int EW = rti_pkg::DetWidth;
   localparam int XW = rti_pkg::DivWidth;
   localparam int NumStages = 7;

   logic [NumStages-1:0] valid_ff;
   rti_pkg::side_type    side_ff [NumStages];

   // Stage 1: edge and origin differences.
   logic signed [DW-1:0] da_in [3], db_in [3], dd_in [3], dr_in [3];
   logic signed [DW-1:0] da_ff [3], db_ff [3], dd_ff [3], dr_ff [3];
   // Stage 2: products for the 2x2 minors; the column a, b, c, d rides along.
   logic signed [2*DW-1:0] fk_ff, gj_ff, hk_ff, gl_ff, fl_ff, hj_ff;
   logic signed [2*DW-1:0] gi_ff, ek_ff, ej_ff, fi_ff, el_ff, hi_ff;
   logic signed [DW-1:0]   a2_ff, b2_ff, c2_ff, d2_ff;
   // Stage 3: minors.
   logic signed [MW-1:0]   m_ff, n_ff, p_ff, q_ff, s_ff, r_ff;
   logic signed [DW-1:0]   a3_ff, b3_ff, c3_ff, d3_ff;
   // Stage 4: column times minor.
   logic signed [PW-1:0]   am_ff, bq_ff, cs_ff, dm_ff, bn_ff, cp_ff;
   logic signed [PW-1:0]   an_ff, dq_ff, cr_ff, ap_ff, br_ff, ds_ff;
   // Stage 5: determinants.
   logic signed [EW-1:0]   den5_ff, e15_ff, e25_ff, e35_ff;
   // Stage 6: denominator made positive.
   logic signed [EW-1:0]   den6_ff, e16_ff, e26_ff, e36_ff;
   logic                   zero6_ff;
   // Stage 7: decisions.
   logic                   miss_in, miss7_ff;
   logic [EW:0]            bound_sum;
   logic [XW-1:0]          num7_ff, den7_ff;

   always_comb begin
      for (int x = 0; x < 3; x++) begin
         da_in[x] = DW'($signed(vertex_a[x])) - DW'($signed(vertex_b[x]));
         db_in[x] = DW'($signed(vertex_a[x])) - DW'($signed(vertex_c[x]));
         dd_in[x] = DW'($signed(vertex_a[x])) - DW'($signed(in_side.origin[x]));
         dr_in[x] = DW'($signed(in_side.dir[x]));
      end
   end

   assign bound_sum = {1'b0, e16_ff} + {1'b0, e26_ff};
   assign miss_in   = side_ff[5].quiet | zero6_ff | e16_ff[EW-1] | e26_ff[EW-1]
                      | e36_ff[EW-1] | (bound_sum > {1'b0, den6_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[NumStages-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         side_ff[0] <= in_side;
         for (int k = 1; k < NumStages; k++) begin
            side_ff[k] <= side_ff[k-1];
         end

         da_ff <= da_in;
         db_ff <= db_in;
         dd_ff <= dd_in;
         dr_ff <= dr_in;

         // a=da0 e=da1 i=da2, b=db0 f=db1 j=db2, c=dr0 g=dr1 k=dr2, d=dd0 h=dd1 l=dd2
         fk_ff <= (2*DW)'(db_ff[1]) * (2*DW)'(dr_ff[2]);
         gj_ff <= (2*DW)'(dr_ff[1]) * (2*DW)'(db_ff[2]);
         hk_ff <= (2*DW)'(dd_ff[1]) * (2*DW)'(dr_ff[2]);
         gl_ff <= (2*DW)'(dr_ff[1]) * (2*DW)'(dd_ff[2]);
         fl_ff <= (2*DW)'(db_ff[1]) * (2*DW)'(dd_ff[2]);
         hj_ff <= (2*DW)'(dd_ff[1]) * (2*DW)'(db_ff[2]);
         gi_ff <= (2*DW)'(dr_ff[1]) * (2*DW)'(da_ff[2]);
         ek_ff <= (2*DW)'(da_ff[1]) * (2*DW)'(dr_ff[2]);
         ej_ff <= (2*DW)'(da_ff[1]) * (2*DW)'(db_ff[2]);
         fi_ff <= (2*DW)'(db_ff[1]) * (2*DW)'(da_ff[2]);
         el_ff <= (2*DW)'(da_ff[1]) * (2*DW)'(dd_ff[2]);
         hi_ff <= (2*DW)'(dd_ff[1]) * (2*DW)'(da_ff[2]);
         a2_ff <= da_ff[0];
         b2_ff <= db_ff[0];
         c2_ff <= dr_ff[0];
         d2_ff <= dd_ff[0];

         m_ff  <= MW'(fk_ff) - MW'(gj_ff);
         n_ff  <= MW'(hk_ff) - MW'(gl_ff);
         p_ff  <= MW'(fl_ff) - MW'(hj_ff);
         q_ff  <= MW'(gi_ff) - MW'(ek_ff);
         s_ff  <= MW'(ej_ff) - MW'(fi_ff);
         r_ff  <= MW'(el_ff) - MW'(hi_ff);
         a3_ff <= a2_ff;
         b3_ff <= b2_ff;
         c3_ff <= c2_ff;
         d3_ff <= d2_ff;

         am_ff <= PW'(a3_ff) * PW'(m_ff);
         bq_ff <= PW'(b3_ff) * PW'(q_ff);
         cs_ff <= PW'(c3_ff) * PW'(s_ff);
         dm_ff <= PW'(d3_ff) * PW'(m_ff);
         bn_ff <= PW'(b3_ff) * PW'(n_ff);
         cp_ff <= PW'(c3_ff) * PW'(p_ff);
         an_ff <= PW'(a3_ff) * PW'(n_ff);
         dq_ff <= PW'(d3_ff) * PW'(q_ff);
         cr_ff <= PW'(c3_ff) * PW'(r_ff);
         ap_ff <= PW'(a3_ff) * PW'(p_ff);
         br_ff <= PW'(b3_ff) * PW'(r_ff);
         ds_ff <= PW'(d3_ff) * PW'(s_ff);

         den5_ff <= EW'(am_ff) + EW'(bq_ff) + EW'(cs_ff);
         e15_ff  <= EW'(dm_ff) - EW'(bn_ff) - EW'(cp_ff);
         e25_ff  <= EW'(an_ff) + EW'(dq_ff) + EW'(cr_ff);
         e35_ff  <= EW'(ap_ff) - EW'(br_ff) + EW'(ds_ff);

         zero6_ff <= (den5_ff == '0);
         if (den5_ff[EW-1]) begin
            den6_ff <= -den5_ff;
            e16_ff  <= -e15_ff;
            e26_ff  <= -e25_ff;
            e36_ff  <= -e35_ff;
         end else begin
            den6_ff <= den5_ff;
            e16_ff  <= e15_ff;
            e26_ff  <= e25_ff;
            e36_ff  <= e35_ff;
         end

         miss7_ff <= miss_in;
         num7_ff  <= XW'(e36_ff) << rti_pkg::FractionBits;
         den7_ff  <= XW'(den6_ff);
      end
   end

   assign out_valid = valid_ff[NumStages-1];
   assign out_side  = side_ff[NumStages-1];
   assign out_miss  = miss7_ff;
   assign out_num   = num7_ff;
   assign out_den   = den7_ff;

endmodule

// ===== hw/rtl/rti_divider.sv =====
// Pipelined restoring divider giving the saturated distance, one quotient bit per stage.
`timescale 1ns / 1ps
module rti_divider (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             advance,
   input  logic                             in_valid,
   input  rti_pkg::side_type                in_side,
   input  logic                             in_miss,
   input  logic [rti_pkg::DivWidth-1:0]     in_num,
   input  logic [rti_pkg::DivWidth-1:0]     in_den,
   output logic                             out_valid,
   output rti_pkg::side_type                out_side,
   output logic                             out_miss,
   output logic [rti_pkg::DistWidth-1:0]    out_t
);

   localparam int XW = rti_pkg::DivWidth;
   localparam int QW = rti_pkg::DistWidth;

   logic [QW:0]        valid_ff;
   rti_pkg::side_type  side_ff [QW+1];
   logic               miss_ff [QW+1];
   logic               sat_ff  [QW+1];
   logic [XW-1:0]      rem_ff  [QW+1];
   logic [XW-1:0]      den_ff  [QW+1];
   logic [QW-1:0]      quo_ff  [QW+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[QW-1:0], in_valid};
      end
   end

   // First stage: a quotient that needs more than QW bits saturates.
   always_ff @(posedge clock) begin
      if (advance) begin
         side_ff[0] <= in_side;
         miss_ff[0] <= in_miss;
         sat_ff[0]  <= in_num >= (in_den << QW);
         rem_ff[0]  <= in_num;
         den_ff[0]  <= in_den;
         quo_ff[0]  <= '0;
      end
   end

   for (genvar j = 0; j < QW; j++) begin : g_step
      localparam int Bit = QW - 1 - j;
      logic [XW-1:0] cand;
      logic          take;

      assign cand = den_ff[j] << Bit;
      assign take = rem_ff[j] >= cand;

      always_ff @(posedge clock) begin
         if (advance) begin
            side_ff[j+1] <= side_ff[j];
            miss_ff[j+1] <= miss_ff[j];
            sat_ff[j+1]  <= sat_ff[j];
            den_ff[j+1]  <= den_ff[j];
            rem_ff[j+1]  <= take ? rem_ff[j] - cand : rem_ff[j];
            quo_ff[j+1]  <= quo_ff[j] | (QW'(take) << Bit);
         end
      end
   end

   assign out_valid = valid_ff[QW];
   assign out_side  = side_ff[QW];
   assign out_miss  = miss_ff[QW];
   assign out_t     = sat_ff[QW] ? '1 : quo_ff[QW];

endmodule

// ===== hw/rtl/rti_point.sv =====
// Epsilon test, hit point origin + t*dir with saturation, and the result register.
`timescale 1ns / 1ps
module rti_point (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             advance,
   input  logic                             in_valid,
   input  rti_pkg::side_type                in_side,
   input  logic                             in_miss,
   input  logic [rti_pkg::DistWidth-1:0]    in_t,
   input  logic [rti_pkg::DistWidth-1:0]    hit_epsilon,
   output logic                             out_valid,
   output rti_pkg::result_type              out_result
);

   localparam int CW = rti_pkg::CoordWidth;
   localparam int SW = rti_pkg::StepWidth;
   localparam logic signed [SW:0] CoordMax = (SW+1)'((1 << (CW - 1)) - 1);
   localparam logic signed [SW:0] CoordMin = -CoordMax - (SW+1)'(1);

   logic                          valid1_ff, valid2_ff;
   logic                          hit1_ff, kind1_ff;
   logic [rti_pkg::DistWidth-1:0] t1_ff;
   rti_pkg::vec_type              origin1_ff;
   logic signed [SW-1:0]          prod1_ff [3];
   rti_pkg::result_type           result_in, result_ff;
   logic signed [SW:0]            sum [3];

   always_comb begin
      result_in.hit      = hit1_ff;
      result_in.primary  = hit1_ff & ~kind1_ff;
      result_in.distance = hit1_ff ? t1_ff : '0;
      for (int x = 0; x < 3; x++) begin
         // Arithmetic shift rounds t*dir towards minus infinity.
         sum[x] = (SW+1)'($signed(origin1_ff[x])) + (SW+1)'(prod1_ff[x] >>> rti_pkg::FractionBits);
         if (!result_in.primary) begin
            result_in.point[x] = '0;
         end else if (sum[x] > CoordMax) begin
            result_in.point[x] = CoordMax[CW-1:0];
         end else if (sum[x] < CoordMin) begin
            result_in.point[x] = CoordMin[CW-1:0];
         end else begin
            result_in.point[x] = sum[x][CW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
      end else if (advance) begin
         valid1_ff <= in_valid;
         valid2_ff <= valid1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         hit1_ff    <= ~in_miss & (in_t >= hit_epsilon);
         kind1_ff   <= in_side.kind;
         t1_ff      <= in_t;
         origin1_ff <= in_side.origin;
         for (int x = 0; x < 3; x++) begin
            prod1_ff[x] <= $signed({1'b0, in_t}) * SW'($signed(in_side.dir[x]));
         end
         result_ff <= result_in;
      end
   end

   assign out_valid  = valid2_ff;
   assign out_result = result_ff;

endmodule
